// ===== hw/rtl/ppu_pkg.sv =====
// ppu_pkg: widths, word types and control structs for the partial
// permutation unrank block. No dependencies.

package ppu_pkg;

   localparam int RANK_W         = 45;
   localparam int COUNT_W        = 5;
   localparam int POOL_W         = 5;
   localparam int INDEX_W        = 4;
   localparam int STEP_CNT_W     = $clog2(RANK_W + 1);
   localparam int PICK_LIMIT     = 16;
   localparam int MAX_POOL_DEFAULT = 16;

   localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(16);

   // CSR register indexes (byte address = 4 * index)
   localparam logic CSR_POOL_SIZE = 1'b0;

   typedef struct packed {
      logic [COUNT_W-1:0] pick_count;
      logic [RANK_W-1:0]  rank;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] chosen_index;
      logic               last;
      logic               invalid;
   } rsp_type;

   // divider control from the sequencer
   typedef struct packed {
      logic start;   // begin one division of the held rank
      logic reload;  // with start: take a fresh dividend first
   } div_ctl_type;

   // index list control from the sequencer
   typedef struct packed {
      logic reload;  // restore identity order
      logic pick;    // remove the entry at pos
   } list_ctl_type;

endpackage

// ===== hw/rtl/ppu_divider.sv =====
// ppu_divider: bit-serial restoring divider, one quotient bit per cycle.
// Holds the remaining rank between divisions. Depends on ppu_pkg.

module ppu_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  ppu_pkg::div_ctl_type        ctl,
   input  logic [ppu_pkg::RANK_W-1:0]  dividend,
   input  logic [ppu_pkg::POOL_W-1:0]  divisor,
   output logic                        done,
   output logic [ppu_pkg::POOL_W-1:0]  remainder
);

   logic                              busy_ff, busy_in;
   logic [ppu_pkg::STEP_CNT_W-1:0]    count_ff, count_in;
   logic [ppu_pkg::RANK_W-1:0]        quot_ff, quot_in;
   logic [ppu_pkg::POOL_W-1:0]        rem_ff, rem_in;
   logic [ppu_pkg::POOL_W:0]          trial;
   logic [ppu_pkg::POOL_W:0]          diff;
   logic                              fits;

   assign trial = {rem_ff, quot_ff[ppu_pkg::RANK_W-1]};
   assign fits  = (trial >= {1'b0, divisor});
   assign diff  = trial - {1'b0, divisor};
   assign done  = busy_ff && (count_ff == '0);
   assign remainder = rem_ff;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         count_in = ppu_pkg::STEP_CNT_W'(ppu_pkg::RANK_W);
         rem_in   = '0;
         if (ctl.reload) begin
            quot_in = dividend;
         end
      end else if (busy_ff) begin
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
            quot_in  = {quot_ff[ppu_pkg::RANK_W-2:0], fits};
            rem_in   = fits ? diff[ppu_pkg::POOL_W-1:0] : trial[ppu_pkg::POOL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
         quot_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
         quot_ff  <= quot_in;
      end
      rem_ff <= rem_in;
   end

endmodule

// ===== hw/rtl/ppu_index_list.sv =====
// ppu_index_list: ordered list of unused pool indices; read at one position
// and close the gap behind it. Depends on ppu_pkg.

module ppu_index_list #(
   parameter int MAX_POOL = ppu_pkg::MAX_POOL_DEFAULT
) (
   input  logic                         clock,
   input  ppu_pkg::list_ctl_type        ctl,
   input  logic [ppu_pkg::POOL_W-1:0]   pos,
   output logic [ppu_pkg::INDEX_W-1:0]  picked
);

   localparam int IDX_W = $clog2(MAX_POOL);

   logic [IDX_W-1:0]                    list_ff [MAX_POOL];
   logic [IDX_W-1:0]                    sel;
   logic [IDX_W+ppu_pkg::INDEX_W-1:0]   picked_wide;
   logic [MAX_POOL-1:0]                 shift_en;

   // position is always below the live count; out-of-range falls back to 0
   assign sel = ({1'b0, pos} >= (ppu_pkg::POOL_W + 1)'(MAX_POOL)) ? '0 : pos[IDX_W-1:0];
   assign picked_wide = {{ppu_pkg::INDEX_W{1'b0}}, list_ff[sel]};
   assign picked = picked_wide[ppu_pkg::INDEX_W-1:0];

   always_comb begin
      for (int k = 0; k < MAX_POOL; k++) begin
         shift_en[k] = (k < MAX_POOL - 1) && (IDX_W'(k) >= sel);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.reload) begin
         for (int k = 0; k < MAX_POOL; k++) begin
            list_ff[k] <= IDX_W'(k);
         end
      end else if (ctl.pick) begin
         for (int k = 0; k < MAX_POOL - 1; k++) begin
            if (shift_en[k]) begin
               list_ff[k] <= list_ff[k+1];
            end
         end
      end
   end

endmodule

// ===== hw/rtl/ppu_csr.sv =====
// ppu_csr: APB-style register file holding pool_size.
// Depends on ppu_pkg.

module ppu_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output logic [ppu_pkg::POOL_W-1:0]  pool_size
);

   logic [ppu_pkg::POOL_W-1:0] pool_size_ff, pool_size_in;
   logic                       hit;

   assign hit        = (csr_paddr[2] == ppu_pkg::CSR_POOL_SIZE);
   assign csr_pready = 1'b1;
   assign pool_size  = pool_size_ff;
   assign csr_prdata = hit ? {{(32 - ppu_pkg::POOL_W){1'b0}}, pool_size_ff} : 32'd0;

   always_comb begin
      pool_size_in = pool_size_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         pool_size_in = csr_pwdata[ppu_pkg::POOL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= ppu_pkg::POOL_RESET;
      end else begin
         pool_size_ff <= pool_size_in;
      end
   end

endmodule

// ===== hw/rtl/partial_permutation_unrank.sv =====
// partial_permutation_unrank: top level; sequencer, output word register.
// Depends on ppu_pkg, ppu_csr, ppu_divider, ppu_index_list.
//
//  channel  direction  handshake            word
//  req      in         req_valid/req_ready  ppu_pkg::req_type {pick_count, rank}
//  rsp      out        rsp_valid/rsp_ready  ppu_pkg::rsp_type {chosen_index, last, invalid}
//  csr      in         APB, pready tied 1   pool_size at byte address 0
//
//  Sequence: each pick runs 45 divider steps, then the divider's done, then
//  an emit that also starts the next division; an item opens with its accept.
//  The pace is set by the bit-serial divider, one quotient bit a cycle.
//  An invalid request goes from accept straight to emit for its single word.
//  Reset: synchronous, active high; pool_size returns to 16.
//  Stalls: a held rsp word blocks the next emit only; the next req word is
//  taken while the final rsp word of the previous item still waits.

module partial_permutation_unrank #(
   parameter int MAX_POOL = ppu_pkg::MAX_POOL_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ppu_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ppu_pkg::rsp_type  rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [ppu_pkg::POOL_W-1:0]         pool_size;
   logic [ppu_pkg::POOL_W-1:0]         pool_eff;
   logic [ppu_pkg::POOL_W-1:0]         avail_ff, avail_in;
   logic [ppu_pkg::COUNT_W-1:0]        picks_left_ff, picks_left_in;
   logic                               invalid_ff, invalid_in;
   logic [ppu_pkg::INDEX_W-1:0]        picked_ff, picked_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ppu_pkg::rsp_type                   rsp_data_ff, rsp_data_in;
   ppu_pkg::div_ctl_type               div_ctl;
   ppu_pkg::list_ctl_type              list_ctl;
   logic                               div_done;
   logic [ppu_pkg::POOL_W-1:0]         div_rem;
   logic [ppu_pkg::INDEX_W-1:0]        list_picked;
   logic                               req_fire;
   logic                               slot_free;
   logic                               bad_count;
   logic                               emit_last;

   ppu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pool_size   (pool_size)
   );

   // remaining rank lives in the divider's quotient register
   ppu_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (req_data.rank),
      .divisor   (avail_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   ppu_index_list #(
      .MAX_POOL (MAX_POOL)
   ) u_list (
      .clock  (clock),
      .ctl    (list_ctl),
      .pos    (div_rem),
      .picked (list_picked)
   );

   // pool saturates at MAX_POOL
   assign pool_eff = ({1'b0, pool_size} > (ppu_pkg::POOL_W + 1)'(MAX_POOL))
                     ? ppu_pkg::POOL_W'(MAX_POOL) : pool_size;

   assign bad_count = (req_data.pick_count == '0)
                   || (req_data.pick_count > pool_eff)
                   || (req_data.pick_count > ppu_pkg::COUNT_W'(ppu_pkg::PICK_LIMIT));

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit_last = invalid_ff || (picks_left_ff == '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      avail_in      = avail_ff;
      picks_left_in = picks_left_ff;
      invalid_in    = invalid_ff;
      picked_in     = picked_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      div_ctl       = '0;
      list_ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               invalid_in = bad_count;
               if (bad_count) begin
                  state_in = ST_EMIT;
               end else begin
                  picks_left_in   = req_data.pick_count;
                  avail_in        = pool_eff;
                  list_ctl.reload = 1'b1;
                  div_ctl.start   = 1'b1;
                  div_ctl.reload  = 1'b1;
                  state_in        = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               // read and remove in the same edge; list reads old contents
               picked_in     = list_picked;
               list_ctl.pick = 1'b1;
               avail_in      = avail_ff - 1'b1;
               picks_left_in = picks_left_ff - 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.chosen_index = invalid_ff ? '0 : picked_ff;
               rsp_data_in.last         = emit_last;
               rsp_data_in.invalid      = invalid_ff;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  div_ctl.start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         avail_ff      <= '0;
         picks_left_ff <= '0;
         invalid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         avail_ff      <= avail_in;
         picks_left_ff <= picks_left_in;
         invalid_ff    <= invalid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      picked_ff   <= picked_in;
      rsp_data_ff <= rsp_data_in;
   end

   // pool never runs dry before the picks are done
   a_avail_covers_picks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && !invalid_ff) |-> (avail_ff >= picks_left_ff))
      else $error("avail below picks left");

   // a rejected request gives a single terminal word with index 0
   a_invalid_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.invalid) |->
      (rsp_data_ff.last && rsp_data_ff.chosen_index == '0))
      else $error("malformed invalid word");

   // divider only finishes while the sequencer waits on it
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");

   // an emit with the slot free always produces a word next cycle
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free) |=> rsp_valid_ff)
      else $error("emit lost a word");

endmodule
